// ===== design/towm_pkg.sv =====
// ----------------------------------------------------------------------------
// towm_pkg
// Shared types, constants and the quarter-wave sine function of the omni mixer.
// ----------------------------------------------------------------------------
package towm_pkg;

  localparam int SPEED_BITS = 8;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int TRIG_W = TRIG_FRAC_BITS + 2;  // signed sine/cosine
  localparam int WV_W = TRIG_FRAC_BITS + 3;    // signed doubled wheel velocity
  localparam int MAG_W = TRIG_FRAC_BITS + 2;   // magnitude of a wheel velocity
  localparam int QUOT_W = SPEED_BITS;
  localparam logic [30:0] SQRT3_Q30 = 31'h6ED9EBA1;
  localparam logic [31:0] PI_Q30 = 32'hC90FDAA2;

  typedef enum logic [1:0] {
    OP_MOVE   = 2'd0,
    OP_ROTATE = 2'd1,
    OP_STOP   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  // Classified command handed from the front to the back end
  typedef struct packed {
    logic                    is_move;
    logic                    is_rotate;
    logic                    rotate_forward;
    logic [SPEED_BITS-1:0]   speed;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } cmd_t;

  // Quarter sine in Q(TRIG_FRAC_BITS), evaluated at elaboration as a constant table
  function automatic logic [TRIG_FRAC_BITS:0] quarter_sine(input logic [6:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s30;
    x = (64'(k) * 64'(PI_Q30) + 64'd90) / 64'd180;
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd156);
    t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd110);
    t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd72);
    t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd42);
    t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd20);
    t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd6);
    s30 = (x * t) >> 30;
    s30 = (s30 + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    return s30[TRIG_FRAC_BITS:0];
  endfunction

endpackage

// ===== design/towm_front.sv =====
// ----------------------------------------------------------------------------
// towm_front
// Accept commands, reduce the heading to a quadrant and look up sin and cos.
// ----------------------------------------------------------------------------
module towm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid,
  output logic                          stall,
  input  logic [1:0]                    opcode,
  input  logic [8:0]                    heading_deg,
  input  logic [7:0]                    speed,
  input  logic                          rotate_forward,
  output logic                          cmd_valid,
  input  logic                          cmd_stall,
  output towm_pkg::cmd_t                cmd
);

  logic [towm_pkg::TRIG_FRAC_BITS:0] qtab [91];
  for (genvar g = 0; g < 91; g++) begin : g_tab
    assign qtab[g] = towm_pkg::quarter_sine(7'(g));
  end

  function automatic logic signed [towm_pkg::TRIG_W-1:0] sine_of(
      input logic [8:0] a, input logic [towm_pkg::TRIG_FRAC_BITS:0] tab [91]);
    logic [8:0] k;
    logic neg;
    k = a;
    neg = 1'b0;
    if (a <= 9'd90) begin
      k = a;
    end else if (a <= 9'd180) begin
      k = 9'd180 - a;
    end else if (a <= 9'd270) begin
      k = a - 9'd180; neg = 1'b1;
    end else begin
      k = 9'd360 - a; neg = 1'b1;
    end
    return neg ? -$signed({1'b0, tab[k[6:0]]}) : $signed({1'b0, tab[k[6:0]]});
  endfunction

  logic [8:0] hdg;
  logic [8:0] hdg_c;
  towm_pkg::cmd_t cmd_next;

  always_comb begin
    hdg = (heading_deg >= 9'd360) ? heading_deg - 9'd360 : heading_deg;
    hdg_c = (hdg >= 9'd270) ? hdg - 9'd270 : hdg + 9'd90;
    cmd_next.is_move = (opcode == towm_pkg::OP_MOVE);
    cmd_next.is_rotate = (opcode == towm_pkg::OP_ROTATE);
    cmd_next.rotate_forward = rotate_forward;
    cmd_next.speed = speed[towm_pkg::SPEED_BITS-1:0];
    cmd_next.sin_v = sine_of(hdg, qtab);
    cmd_next.cos_v = sine_of(hdg_c, qtab);
  end

  assign stall = cmd_valid && cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!stall) begin
      cmd_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && valid) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ===== design/towm_queue.sv =====
// ----------------------------------------------------------------------------
// towm_queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module towm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  towm_pkg::cmd_t in_cmd,
  output logic           out_valid,
  input  logic           out_stall,
  output towm_pkg::cmd_t out_cmd
);

  towm_pkg::cmd_t slot [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic push;
  logic pop;

  assign in_stall = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd = slot[rd_ptr];
  assign push = in_valid && !in_stall;
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
  end

endmodule

// ===== design/towm_back.sv =====
// ----------------------------------------------------------------------------
// towm_back
// Form wheel velocities, find the peak and scale each wheel by speed/peak.
// Stage 1: sqrt3*cos. Stage 2: wheel terms and peak. Stage 3: speed*|w|.
// Stages 4..11: restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module towm_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  towm_pkg::cmd_t                    cmd,
  output logic                              valid,
  input  logic                              stall,
  output logic                              wheel1_forward,
  output logic [7:0]                        wheel1_duty,
  output logic                              wheel2_forward,
  output logic [7:0]                        wheel2_duty,
  output logic                              wheel3_forward,
  output logic [7:0]                        wheel3_duty
);

  localparam int F = towm_pkg::TRIG_FRAC_BITS;
  localparam int SB = towm_pkg::SPEED_BITS;
  localparam int MW = towm_pkg::MAG_W;
  localparam int PW = MW + SB;
  localparam int NS = 2 + SB;

  typedef struct packed {
    logic          is_move;
    logic          is_rotate;
    logic          rotate_forward;
    logic [SB-1:0] speed;
    logic [2:0]    fwd;
    logic [MW-1:0] peak;
    logic [PW-1:0] rem1, rem2, rem3;
    logic [SB-1:0] q1, q2, q3;
  } stage_t;

  typedef struct packed {
    logic          is_move;
    logic          is_rotate;
    logic          rotate_forward;
    logic [SB-1:0] speed;
    logic          cos_neg;
    logic [F:0]    pm;
    logic signed [towm_pkg::TRIG_W-1:0] sin_v;
  } s1_t;

  typedef struct packed {
    logic          is_move;
    logic          is_rotate;
    logic          rotate_forward;
    logic [SB-1:0] speed;
    logic [2:0]    fwd;
    logic [MW-1:0] m1, m2, m3, peak;
  } s2_t;

  logic [NS:0] vld;
  logic adv;
  assign adv = !(vld[NS] && stall);
  assign cmd_stall = !adv;
  assign valid = vld[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-1:0], cmd_valid};
    end
  end

  // Stage 1: magnitude of sqrt3*cos, rounded half up
  s1_t s1;
  logic [F:0] cmag;
  logic [F+31:0] prod;
  always_comb begin
    cmag = cmd.cos_v[F+1] ? (F+1)'(0) - cmd.cos_v[F:0] : cmd.cos_v[F:0];
    prod = (F+32)'(cmag) * (F+32)'(towm_pkg::SQRT3_Q30) + ((F+32)'(1) << 29);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1.is_move <= cmd.is_move;
      s1.is_rotate <= cmd.is_rotate;
      s1.rotate_forward <= cmd.rotate_forward;
      s1.speed <= cmd.speed;
      s1.cos_neg <= cmd.cos_v[F+1];
      s1.pm <= prod[F+30:30];
      s1.sin_v <= cmd.sin_v;
    end
  end

  // Stage 2: doubled wheel velocities and their peak magnitude
  s2_t s2;
  logic signed [towm_pkg::WV_W-1:0] p, sv, w1, w2, w3;
  logic [MW-1:0] a1, a2, a3, pk;
  always_comb begin
    p = s1.cos_neg ? -$signed({2'b00, s1.pm}) : $signed({2'b00, s1.pm});
    sv = towm_pkg::WV_W'(s1.sin_v);
    w1 = -(p + sv);
    w2 = p - sv;
    w3 = sv <<< 1;
    a1 = MW'(w1[towm_pkg::WV_W-1] ? -w1 : w1);
    a2 = MW'(w2[towm_pkg::WV_W-1] ? -w2 : w2);
    a3 = MW'(w3[towm_pkg::WV_W-1] ? -w3 : w3);
    pk = (a1 > a2) ? a1 : a2;
    pk = (a3 > pk) ? a3 : pk;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2.is_move <= s1.is_move;
      s2.is_rotate <= s1.is_rotate;
      s2.rotate_forward <= s1.rotate_forward;
      s2.speed <= s1.speed;
      s2.fwd <= {~w3[towm_pkg::WV_W-1], ~w2[towm_pkg::WV_W-1], ~w1[towm_pkg::WV_W-1]};
      s2.m1 <= a1;
      s2.m2 <= a2;
      s2.m3 <= a3;
      s2.peak <= pk;
    end
  end

  // Stage 3 onward: dividend speed*|w|, then one quotient bit per stage
  stage_t st [SB+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].is_move <= s2.is_move;
      st[0].is_rotate <= s2.is_rotate;
      st[0].rotate_forward <= s2.rotate_forward;
      st[0].speed <= s2.speed;
      st[0].fwd <= s2.fwd;
      st[0].peak <= s2.peak;
      st[0].rem1 <= PW'(s2.speed) * PW'(s2.m1);
      st[0].rem2 <= PW'(s2.speed) * PW'(s2.m2);
      st[0].rem3 <= PW'(s2.speed) * PW'(s2.m3);
      st[0].q1 <= '0;
      st[0].q2 <= '0;
      st[0].q3 <= '0;
    end
  end

  for (genvar i = 0; i < SB; i++) begin : g_div
    localparam int B = SB - 1 - i;
    logic [PW+SB-1:0] dsh;
    logic t1, t2, t3;
    stage_t nx;
    always_comb begin
      dsh = (PW+SB)'(st[i].peak) << B;
      t1 = ((PW+SB)'(st[i].rem1) >= dsh) && (st[i].peak != '0);
      t2 = ((PW+SB)'(st[i].rem2) >= dsh) && (st[i].peak != '0);
      t3 = ((PW+SB)'(st[i].rem3) >= dsh) && (st[i].peak != '0);
      nx = st[i];
      if (t1) begin
        nx.rem1 = st[i].rem1 - PW'(dsh);
        nx.q1[B] = 1'b1;
      end
      if (t2) begin
        nx.rem2 = st[i].rem2 - PW'(dsh);
        nx.q2[B] = 1'b1;
      end
      if (t3) begin
        nx.rem3 = st[i].rem3 - PW'(dsh);
        nx.q3[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        st[i+1] <= nx;
      end
    end
  end

  stage_t f;
  assign f = st[SB];
  always_comb begin
    if (f.is_rotate) begin
      wheel1_forward = f.rotate_forward;
      wheel2_forward = f.rotate_forward;
      wheel3_forward = f.rotate_forward;
      wheel1_duty = 8'(f.speed);
      wheel2_duty = 8'(f.speed);
      wheel3_duty = 8'(f.speed);
    end else if (f.is_move) begin
      wheel1_forward = f.fwd[0];
      wheel2_forward = f.fwd[1];
      wheel3_forward = f.fwd[2];
      wheel1_duty = 8'(f.q1);
      wheel2_duty = 8'(f.q2);
      wheel3_duty = 8'(f.q3);
    end else begin
      wheel1_forward = 1'b0;
      wheel2_forward = 1'b0;
      wheel3_forward = 1'b0;
      wheel1_duty = '0;
      wheel2_duty = '0;
      wheel3_duty = '0;
    end
  end

endmodule

// ===== design/three_wheel_omni_drive_mixer.sv =====
// Three-wheel omni drive mixer. One command in gives one wheel-drive result
// out, in order. The block takes a command every cycle unless in_stall is
// high; each result passes the front end, the command queue and the back end,
// whose 8-stage restoring divider scales each wheel by speed over the peak
// wheel velocity. A two-entry queue separates command classification and the
// sine/cosine lookup from the scaling pipeline.
// ----------------------------------------------------------------------------
// three_wheel_omni_drive_mixer
// Top level: front end, command queue and scaling back end.
// ----------------------------------------------------------------------------
module three_wheel_omni_drive_mixer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [8:0] heading_deg,
  input  logic [7:0] speed,
  input  logic       rotate_forward,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       wheel1_forward,
  output logic [7:0] wheel1_duty,
  output logic       wheel2_forward,
  output logic [7:0] wheel2_duty,
  output logic       wheel3_forward,
  output logic [7:0] wheel3_duty
);

  logic f_valid, f_stall, q_valid, q_stall;
  towm_pkg::cmd_t f_cmd, q_cmd;

  towm_front u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .stall(in_stall),
    .opcode(opcode), .heading_deg(heading_deg), .speed(speed),
    .rotate_forward(rotate_forward),
    .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd(f_cmd)
  );

  towm_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(f_valid), .in_stall(f_stall), .in_cmd(f_cmd),
    .out_valid(q_valid), .out_stall(q_stall), .out_cmd(q_cmd)
  );

  towm_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(q_valid), .cmd_stall(q_stall), .cmd(q_cmd),
    .valid(out_valid), .stall(out_stall),
    .wheel1_forward(wheel1_forward), .wheel1_duty(wheel1_duty),
    .wheel2_forward(wheel2_forward), .wheel2_duty(wheel2_duty),
    .wheel3_forward(wheel3_forward), .wheel3_duty(wheel3_duty)
  );

endmodule

// ===== design/towm_checker.sv =====
// ----------------------------------------------------------------------------
// towm_checker
// Port-level checks of the omni mixer, bound to the top level.
// ----------------------------------------------------------------------------
module towm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       wheel1_forward,
  input logic [7:0] wheel1_duty,
  input logic       wheel2_forward,
  input logic [7:0] wheel2_duty,
  input logic       wheel3_forward,
  input logic [7:0] wheel3_duty
);

  // A stalled result stays valid with wheel1 and wheel2 duty held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(wheel1_duty) && $stable(wheel2_duty))
    else $error("stalled result changed");

  // A presented result carries no unknown bits
  a_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown({wheel1_forward, wheel1_duty, wheel2_forward, wheel2_duty,
                               wheel3_forward, wheel3_duty}))
    else $error("result with unknown bits");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result right after reset");

endmodule

bind three_wheel_omni_drive_mixer towm_checker u_towm_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .wheel1_forward(wheel1_forward), .wheel1_duty(wheel1_duty),
  .wheel2_forward(wheel2_forward), .wheel2_duty(wheel2_duty),
  .wheel3_forward(wheel3_forward), .wheel3_duty(wheel3_duty)
);
